>>> rtl/cdlfir_pkg.sv
// Shared types and constants for the complex delay line FIR MAC block.
// Used by the channel interfaces, the front, queue and back modules and the top level.
// No dependencies.
package cdlfir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int RES_W      = 40;
  localparam int IDX_W      = 8;
  localparam int DELAY_W    = 8;
  localparam int NTAPS_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QDEPTH     = 2;

  localparam logic [NTAPS_W-1:0] NUM_TAPS_RST = NTAPS_W'(64);

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_OFFSET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_TAPS     = CFG_IDX_W'(1);

  localparam logic RES_MAC    = 1'b0;
  localparam logic RES_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_COEF = 2'd1,
    CMD_MAC  = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_MAC,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    cmd_t                       op;
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
    logic [IDX_W-1:0]           tap_index;
    logic signed [SAMPLE_W-1:0] coef_re;
    logic signed [SAMPLE_W-1:0] coef_im;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } enq_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } bk_status_t;

endpackage

>>> rtl/cdlfir_if.sv
// Valid/ready channel interfaces for the command, result and configuration ports.
// Depends on cdlfir_pkg for field widths.
interface cdlfir_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             cmd;
  logic signed [cdlfir_pkg::SAMPLE_W-1:0] sample_re;
  logic signed [cdlfir_pkg::SAMPLE_W-1:0] sample_im;
  logic [cdlfir_pkg::IDX_W-1:0]           tap_index;
  logic signed [cdlfir_pkg::SAMPLE_W-1:0] coef_re;
  logic signed [cdlfir_pkg::SAMPLE_W-1:0] coef_im;

  modport source (output valid, cmd, sample_re, sample_im, tap_index, coef_re, coef_im,
                  input ready);
  modport sink (input valid, cmd, sample_re, sample_im, tap_index, coef_re, coef_im,
                output ready);
endinterface

interface cdlfir_out_if;
  logic                                valid;
  logic                                ready;
  logic                                result_kind;
  logic signed [cdlfir_pkg::RES_W-1:0] result_re;
  logic signed [cdlfir_pkg::RES_W-1:0] result_im;

  modport source (output valid, result_kind, result_re, result_im, input ready);
  modport sink (input valid, result_kind, result_re, result_im, output ready);
endinterface

interface cdlfir_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cdlfir_pkg::CFG_IDX_W-1:0]  index;
  logic [cdlfir_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/cdlfir_front.sv
// Front end: accepts command items, classifies them and hands them to the queue.
// Depends on cdlfir_pkg and cdlfir_in_if.
module cdlfir_front #(
  parameter int MAX_TAPS = 256
) (
  cdlfir_in_if.sink             in_if,
  input  logic                  q_full,
  input  cdlfir_pkg::bk_status_t bk_stat,
  output cdlfir_pkg::enq_t      enq
);

  logic keep;

  assign in_if.ready = !q_full && !bk_stat.clearing;

  // Coefficient writes past the end of the table are dropped here and never queued.
  always_comb begin
    keep = 1'b1;
    unique case (cdlfir_pkg::cmd_t'(in_if.cmd))
      cdlfir_pkg::CMD_COEF: keep = (int'(in_if.tap_index) < MAX_TAPS);
      default:              keep = 1'b1;
    endcase
  end

  always_comb begin
    enq.valid          = in_if.valid && in_if.ready && keep;
    enq.item.op        = cdlfir_pkg::cmd_t'(in_if.cmd);
    enq.item.sample_re = in_if.sample_re;
    enq.item.sample_im = in_if.sample_im;
    enq.item.tap_index = in_if.tap_index;
    enq.item.coef_re   = in_if.coef_re;
    enq.item.coef_im   = in_if.coef_im;
  end

endmodule

>>> rtl/cdlfir_queue.sv
// Short FIFO of classified items between the front end and the execution back end.
// Depends on cdlfir_pkg.
module cdlfir_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  cdlfir_pkg::enq_t    enq,
  input  logic                pop,
  output cdlfir_pkg::q_item_t head,
  output logic                head_valid,
  output logic                full
);

  localparam int PW  = (cdlfir_pkg::QDEPTH > 1) ? $clog2(cdlfir_pkg::QDEPTH) : 1;
  localparam int CNW = $clog2(cdlfir_pkg::QDEPTH + 1);

  cdlfir_pkg::q_item_t q_mem [cdlfir_pkg::QDEPTH];

  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNW-1:0] count_r, count_nxt;
  logic           do_push, do_pop;

  assign full       = (count_r == CNW'(cdlfir_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = q_mem[rd_ptr_r];
  assign do_push    = enq.valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(cdlfir_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(cdlfir_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= enq.item;
    end
  end

endmodule

>>> rtl/cdlfir_back.sv
// Back end: owns the sample ring and coefficient memories, executes queued items
// and drives the result register. Depends on cdlfir_pkg and cdlfir_out_if.
module cdlfir_back #(
  parameter int LINE_SIZE = 256,
  parameter int MAX_TAPS  = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  cdlfir_pkg::q_item_t                 q_item,
  output logic                                q_pop,
  input  logic [cdlfir_pkg::DELAY_W-1:0]      delay_offset,
  input  logic [cdlfir_pkg::NTAPS_W-1:0]      num_taps,
  output cdlfir_pkg::bk_status_t              stat,
  cdlfir_out_if.source                        out_if
);

  localparam int SW      = cdlfir_pkg::SAMPLE_W;
  localparam int RW      = cdlfir_pkg::RES_W;
  localparam int LW      = $clog2(LINE_SIZE);
  localparam int TW      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW      = $clog2(MAX_TAPS + 1);
  localparam int CLR_LEN = (LINE_SIZE > MAX_TAPS) ? LINE_SIZE : MAX_TAPS;
  localparam int CLRW    = $clog2(CLR_LEN);
  localparam int MW0     = (LW > CW) ? LW : CW;
  localparam int MW      = (MW0 > cdlfir_pkg::DELAY_W) ? MW0 : cdlfir_pkg::DELAY_W;
  localparam int SUMW    = MW + 2;
  localparam int ACCW    = 2 * SW + TW + 1;
  localparam int EXTW    = (ACCW > RW) ? ACCW : RW;

  localparam logic signed [RW-1:0] SUM_MAX = {1'b0, {(RW-1){1'b1}}};
  localparam logic signed [RW-1:0] SUM_MIN = {1'b1, {(RW-1){1'b0}}};

  logic [2*SW-1:0] ring_mem [LINE_SIZE];
  logic [2*SW-1:0] tap_mem  [MAX_TAPS];

  cdlfir_pkg::bk_state_t state_r, state_nxt;
  cdlfir_pkg::cmd_t      op_r, op_nxt;
  logic [CLRW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [CW-1:0]         issue_cnt_r, issue_cnt_nxt;
  logic [LW-1:0]         write_pos_r, write_pos_nxt;
  logic [LW-1:0]         newest_pos_r, newest_pos_nxt;
  logic                  rd_v_r, rd_v_nxt;
  logic                  mul_v_r;
  logic                  out_valid_r, out_valid_nxt;

  logic                  ring_we, ring_rd;
  logic [LW-1:0]         ring_waddr, ring_raddr;
  logic [2*SW-1:0]       ring_wdata;
  logic                  tap_we, tap_rd;
  logic [TW-1:0]         tap_waddr, tap_raddr;
  logic [2*SW-1:0]       tap_wdata;
  logic                  acc_clr, out_load;
  logic [CW-1:0]         n_lim;
  logic [SUMW-1:0]       slot_sum;

  logic signed [SW-1:0]   ring_re_q_r, ring_im_q_r;
  logic signed [SW-1:0]   tap_re_q_r, tap_im_q_r;
  logic signed [2*SW-1:0] prod_re_r, prod_im_r;
  logic signed [ACCW-1:0] acc_re_r, acc_im_r;
  logic signed [RW-1:0]   mac_re, mac_im;
  logic                   res_kind_r;
  logic signed [RW-1:0]   res_re_r, res_im_r;

  function automatic logic signed [RW-1:0] sat_sum(input logic signed [ACCW-1:0] acc);
    logic signed [EXTW-1:0] ext;
    logic [EXTW-RW:0]       hi;
    logic signed [RW-1:0]   res;
    ext = EXTW'(acc);
    hi  = ext[EXTW-1:RW-1];
    if ((hi != '0) && (hi != '1)) begin
      res = ext[EXTW-1] ? SUM_MIN : SUM_MAX;
    end else begin
      res = ext[RW-1:0];
    end
    return res;
  endfunction

  assign n_lim = (int'(num_taps) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(num_taps);

  // Tap slot: newest sample plus delay plus tap offset, modulo the ring size.
  always_comb begin
    slot_sum = SUMW'(newest_pos_r) + SUMW'(delay_offset);
    if (state_r == cdlfir_pkg::BK_MAC) begin
      slot_sum = slot_sum + SUMW'(issue_cnt_r);
    end else begin
      slot_sum = slot_sum + SUMW'(q_item.tap_index);
    end
  end

  assign mac_re = sat_sum(acc_re_r);
  assign mac_im = sat_sum(acc_im_r);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    clr_cnt_nxt    = clr_cnt_r;
    issue_cnt_nxt  = issue_cnt_r;
    write_pos_nxt  = write_pos_r;
    newest_pos_nxt = newest_pos_r;
    rd_v_nxt       = 1'b0;
    q_pop          = 1'b0;
    ring_we        = 1'b0;
    ring_waddr     = write_pos_r;
    ring_wdata     = {q_item.sample_re, q_item.sample_im};
    ring_rd        = 1'b0;
    ring_raddr     = slot_sum[LW-1:0];
    tap_we         = 1'b0;
    tap_waddr      = TW'(q_item.tap_index);
    tap_wdata      = {q_item.coef_re, q_item.coef_im};
    tap_rd         = 1'b0;
    tap_raddr      = issue_cnt_r[TW-1:0];
    acc_clr        = 1'b0;
    out_load       = 1'b0;

    unique case (state_r)
      cdlfir_pkg::BK_CLEAR: begin
        ring_we     = 1'b1;
        ring_waddr  = clr_cnt_r[LW-1:0];
        ring_wdata  = '0;
        tap_we      = (int'(clr_cnt_r) < MAX_TAPS);
        tap_waddr   = TW'(clr_cnt_r);
        tap_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLRW'(CLR_LEN - 1)) begin
          state_nxt = cdlfir_pkg::BK_IDLE;
        end
      end
      cdlfir_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            cdlfir_pkg::CMD_PUSH: begin
              ring_we        = 1'b1;
              newest_pos_nxt = write_pos_r;
              write_pos_nxt  = write_pos_r - 1'b1;
            end
            cdlfir_pkg::CMD_COEF: begin
              tap_we = 1'b1;
            end
            cdlfir_pkg::CMD_MAC: begin
              acc_clr       = 1'b1;
              issue_cnt_nxt = '0;
              op_nxt        = cdlfir_pkg::CMD_MAC;
              state_nxt     = cdlfir_pkg::BK_MAC;
            end
            cdlfir_pkg::CMD_READ: begin
              ring_rd   = 1'b1;
              op_nxt    = cdlfir_pkg::CMD_READ;
              state_nxt = cdlfir_pkg::BK_DONE;
            end
            default: begin
            end
          endcase
        end
      end
      cdlfir_pkg::BK_MAC: begin
        // One tap is issued per cycle; the product and accumulate stages drain after.
        if (issue_cnt_r != n_lim) begin
          ring_rd       = 1'b1;
          tap_rd        = 1'b1;
          rd_v_nxt      = 1'b1;
          issue_cnt_nxt = issue_cnt_r + 1'b1;
        end else if (!rd_v_r && !mul_v_r) begin
          state_nxt = cdlfir_pkg::BK_DONE;
        end
      end
      cdlfir_pkg::BK_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = cdlfir_pkg::BK_IDLE;
        end
      end
      default: state_nxt = cdlfir_pkg::BK_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cdlfir_pkg::BK_CLEAR;
      op_r         <= cdlfir_pkg::CMD_MAC;
      clr_cnt_r    <= '0;
      issue_cnt_r  <= '0;
      write_pos_r  <= '0;
      newest_pos_r <= '0;
      rd_v_r       <= 1'b0;
      mul_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      issue_cnt_r  <= issue_cnt_nxt;
      write_pos_r  <= write_pos_nxt;
      newest_pos_r <= newest_pos_nxt;
      rd_v_r       <= rd_v_nxt;
      mul_v_r      <= rd_v_r;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    if (ring_rd) begin
      {ring_re_q_r, ring_im_q_r} <= ring_mem[ring_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[tap_waddr] <= tap_wdata;
    end
    if (tap_rd) begin
      {tap_re_q_r, tap_im_q_r} <= tap_mem[tap_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      prod_re_r <= ring_re_q_r * tap_re_q_r;
      prod_im_r <= ring_im_q_r * tap_im_q_r;
    end
    if (acc_clr) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (mul_v_r) begin
      acc_re_r <= acc_re_r + ACCW'(prod_re_r);
      acc_im_r <= acc_im_r + ACCW'(prod_im_r);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (op_r == cdlfir_pkg::CMD_MAC) begin
        res_kind_r <= cdlfir_pkg::RES_MAC;
        res_re_r   <= mac_re;
        res_im_r   <= mac_im;
      end else begin
        res_kind_r <= cdlfir_pkg::RES_SAMPLE;
        res_re_r   <= RW'(ring_re_q_r);
        res_im_r   <= RW'(ring_im_q_r);
      end
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.result_kind = res_kind_r;
  assign out_if.result_re   = res_re_r;
  assign out_if.result_im   = res_im_r;

  assign stat.clearing = (state_r == cdlfir_pkg::BK_CLEAR);
  assign stat.busy     = (state_r != cdlfir_pkg::BK_IDLE);

endmodule

>>> rtl/complex_delay_line_fir_mac_core.sv
// Complex delay line with a tap-by-tap multiply-accumulate. After reset the block runs a
// clearing pass over max(LINE_SIZE, MAX_TAPS) entries (256 at the defaults), during which no
// item is accepted; configuration writes are taken at any time. Items pass through a
// two-entry queue, so the input side keeps accepting while a result waits to be taken,
// until the queue is full. A push or coefficient write is executed in the idle state; a
// delayed-sample read also passes through the done state. A MAC runs over
// min(num_taps, MAX_TAPS) taps: the sample ring and the coefficient table each have one
// read port, and one multiplier pair handles one tap per cycle. Each MAC result holds the
// saturated 40-bit sums of re*coef_re and of im*coef_im.
// Depends on cdlfir_pkg, the channel interfaces and the front, queue and back modules.
module complex_delay_line_fir_mac_core #(
  parameter int LINE_SIZE = 256,
  parameter int MAX_TAPS  = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  cdlfir_in_if.sink    in_if,
  cdlfir_out_if.source out_if,
  cdlfir_cfg_if.sink   cfg_if
);

  logic [cdlfir_pkg::DELAY_W-1:0] delay_offset_r;
  logic [cdlfir_pkg::NTAPS_W-1:0] num_taps_r;

  cdlfir_pkg::enq_t       enq;
  cdlfir_pkg::q_item_t    q_head;
  cdlfir_pkg::bk_status_t bk_stat;
  logic                   q_valid;
  logic                   q_full;
  logic                   q_pop;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_offset_r <= '0;
      num_taps_r     <= cdlfir_pkg::NUM_TAPS_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.index)
        cdlfir_pkg::CFG_DELAY_OFFSET: delay_offset_r <= cfg_if.data[cdlfir_pkg::DELAY_W-1:0];
        cdlfir_pkg::CFG_NUM_TAPS:     num_taps_r     <= cfg_if.data[cdlfir_pkg::NTAPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cdlfir_front #(
    .MAX_TAPS (MAX_TAPS)
  ) u_front (
    .in_if   (in_if),
    .q_full  (q_full),
    .bk_stat (bk_stat),
    .enq     (enq)
  );

  cdlfir_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .enq        (enq),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid),
    .full       (q_full)
  );

  cdlfir_back #(
    .LINE_SIZE (LINE_SIZE),
    .MAX_TAPS  (MAX_TAPS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_item       (q_head),
    .q_pop        (q_pop),
    .delay_offset (delay_offset_r),
    .num_taps     (num_taps_r),
    .stat         (bk_stat),
    .out_if       (out_if)
  );

  // The front end must never hand an item to a full queue.
  a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    enq.valid |-> !q_full)
    else $error("item queued while the queue is full");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |-> !bk_stat.clearing)
    else $error("item accepted during the clearing pass");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.clearing |-> !out_if.valid)
    else $error("result presented during the clearing pass");

  // The back end only takes work from the queue while it is idle.
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && !bk_stat.busy))
    else $error("queue popped while the back end is busy");

endmodule
